@@ sv/lbps_pkg.sv @@
package lbps_pkg;

   // Field widths
   localparam int PIX_W      = 16;
   localparam int ANG_W      = 16;
   localparam int IDX_W      = 6;
   localparam int CONF_W     = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indices
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BAR_ASPECT      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BAR_ASPECT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ANGLE_DIFF      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SIZE_MISMATCH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VERTICAL_OFFSET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPACING_RATIO   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPACING_RATIO   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IDEAL_SPACING_RATIO = 3'd7;

   // Register reset values
   localparam logic [9:0]  RST_MIN_BAR_ASPECT      = 10'd26;
   localparam logic [9:0]  RST_MAX_BAR_ASPECT      = 10'd128;
   localparam logic [14:0] RST_MAX_ANGLE_DIFF      = 15'd1280;
   localparam logic [8:0]  RST_MAX_SIZE_MISMATCH   = 9'd128;
   localparam logic [9:0]  RST_MAX_VERTICAL_OFFSET = 10'd205;
   localparam logic [9:0]  RST_MIN_SPACING_RATIO   = 10'd205;
   localparam logic [10:0] RST_MAX_SPACING_RATIO   = 11'd768;
   localparam logic [10:0] RST_IDEAL_SPACING_RATIO = 11'd614;

   // Angle constants, degrees 8.8
   localparam logic [16:0] HALF_TURN    = 17'd46080;
   localparam logic [16:0] QUARTER_TURN = 17'd23040;
   localparam logic [14:0] ANGLE_REF    = 15'd1280;

   // Divide by ten: reciprocal and shift, one correction step
   localparam logic [17:0] DIV10_MULT  = 18'd209716;
   localparam int          DIV10_SHIFT = 21;

   // Unit widths
   localparam int SQRT_IN_W = 49;
   localparam int SQRT_W    = (SQRT_IN_W + 1) / 2;
   localparam int SCORE_Q   = 17;
   localparam int RATIO_Q   = 19;

   typedef enum logic [2:0] {
      CAUSE_NONE     = 3'd0,
      CAUSE_ASPECT   = 3'd1,
      CAUSE_ANGLE    = 3'd2,
      CAUSE_SIZE     = 3'd3,
      CAUSE_VERTICAL = 3'd4,
      CAUSE_SPACING  = 3'd5
   } cause_type;

   typedef struct packed {
      logic [9:0]  min_bar_aspect;
      logic [9:0]  max_bar_aspect;
      logic [14:0] max_angle_diff;
      logic [8:0]  max_size_mismatch;
      logic [9:0]  max_vertical_offset;
      logic [9:0]  min_spacing_ratio;
      logic [10:0] max_spacing_ratio;
      logic [10:0] ideal_spacing_ratio;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic [14:0]      ang;
      logic [PIX_W-1:0] aw;
      logic [PIX_W-1:0] ah;
      logic [PIX_W-1:0] bw;
      logic [PIX_W-1:0] bh;
      logic [PIX_W-1:0] mh;
      logic [PIX_W-1:0] mw;
      logic [PIX_W-1:0] nh;
      logic [PIX_W-1:0] nw;
      logic [PIX_W-1:0] dh;
      logic [PIX_W-1:0] dw;
      logic [PIX_W-1:0] dx;
      logic [PIX_W-1:0] dy;
   } s1_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic             aspect_bad;
      logic             angle_bad;
      logic             size_bad;
      logic             vert_bad;
      logic [31:0]      dx2;
      logic [31:0]      dy2;
      logic [25:0]      lo;
      logic [26:0]      hi;
      logic [PIX_W-1:0] mh;
   } s2_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic             aspect_bad;
      logic             angle_bad;
      logic             size_bad;
      logic             vert_bad;
      logic [32:0]      d2;
      logic [51:0]      lo2;
      logic [53:0]      hi2;
      logic [PIX_W-1:0] mh;
   } s3_type;

   typedef struct packed {
      logic                 valid;
      logic [IDX_W-1:0]     left;
      logic [IDX_W-1:0]     right;
      cause_type            cause;
      logic [PIX_W-1:0]     mh;
      logic [SQRT_IN_W-1:0] lhs;
   } s4_type;

   typedef struct packed {
      logic             valid;
      cause_type        cause;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
   } side_type;

endpackage

@@ sv/lbps_delay.sv @@
module lbps_delay
   import lbps_pkg::*;
#(
   parameter int W = PIX_W,
   parameter int N = SQRT_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] line_ff [N];

   // Advance the line one place per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) line_ff[k] <= '0;
      end else begin
         line_ff[0] <= din;
         for (int k = 1; k < N; k++) line_ff[k] <= line_ff[k-1];
      end
   end

   assign dout = line_ff[N-1];

endmodule

@@ sv/lbps_div.sv @@
module lbps_div
   import lbps_pkg::*;
#(
   parameter int NW = 32,
   parameter int DW = PIX_W,
   parameter int QW = SCORE_Q
) (
   input  logic          clock,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic [NW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [NW-1:0] rem_in [QW];
   logic [QW-1:0] quo_in [QW];
   logic [NW-1:0] r_prev [QW];
   logic [DW-1:0] d_prev [QW];
   logic [QW-1:0] q_prev [QW];

   // One quotient bit per stage, most significant first
   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int B = QW - 1 - k;
      logic [CW-1:0] shd;
      logic          take;

      if (k == 0) begin : g_first
         assign r_prev[k] = num;
         assign d_prev[k] = den;
         assign q_prev[k] = '0;
      end else begin : g_next
         assign r_prev[k] = rem_ff[k-1];
         assign d_prev[k] = den_ff[k-1];
         assign q_prev[k] = quo_ff[k-1];
      end

      assign shd       = CW'(d_prev[k]) << B;
      assign take      = CW'(r_prev[k]) >= shd;
      assign rem_in[k] = take ? r_prev[k] - shd[NW-1:0] : r_prev[k];
      assign quo_in[k] = q_prev[k] | (QW'(take) << B);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QW; k++) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= d_prev[k];
         quo_ff[k] <= quo_in[k];
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

@@ sv/lbps_sqrt.sv @@
module lbps_sqrt
   import lbps_pkg::*;
#(
   parameter int VW = SQRT_IN_W
) (
   input  logic                  clock,
   input  logic [VW-1:0]         value,
   output logic [(VW+1)/2-1:0]   root
);

   localparam int RW = (VW + 1) / 2;
   localparam int TW = VW + 2;

   logic [VW-1:0] rem_ff [RW];
   logic [RW-1:0] res_ff [RW];
   logic [VW-1:0] rem_in [RW];
   logic [RW-1:0] res_in [RW];
   logic [VW-1:0] r_prev [RW];
   logic [RW-1:0] s_prev [RW];

   // One root bit per stage; the remainder holds value minus root squared
   for (genvar k = 0; k < RW; k++) begin : g_stage
      localparam int I = RW - 1 - k;
      logic [TW-1:0] term;
      logic          take;

      if (k == 0) begin : g_first
         assign r_prev[k] = value;
         assign s_prev[k] = '0;
      end else begin : g_next
         assign r_prev[k] = rem_ff[k-1];
         assign s_prev[k] = res_ff[k-1];
      end

      assign term      = (TW'(s_prev[k]) << (I + 1)) + (TW'(1) << (2 * I));
      assign take      = TW'(r_prev[k]) >= term;
      assign rem_in[k] = take ? r_prev[k] - term[VW-1:0] : r_prev[k];
      assign res_in[k] = s_prev[k] | (RW'(take) << I);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < RW; k++) begin
         rem_ff[k] <= rem_in[k];
         res_ff[k] <= res_in[k];
      end
   end

   assign root = res_ff[RW-1];

endmodule

@@ sv/light_bar_pair_filter_score.sv @@
// Channel    | Ports                  | Handshake
// -----------+------------------------+------------------------------------
// request    | start, busy, req_*     | item taken when start and not busy
// response   | rsp_valid, rsp_*       | one-cycle strobe, cannot be held off
// registers  | csr_valid, csr_ready,  | written when valid and ready
//            | csr_index, csr_data    |
//
// One item enters per cycle; busy stays low and csr_ready stays high.
// Each item taken passes through four filter stages, a 25-stage square
// root, a 19-stage ratio divider, one difference stage, a 17-stage score
// divider and three stages of weighting and divide by ten before its
// response comes out. The size and angle dividers run beside the root.
// Reset clears the valid bits and loads the register defaults.
module light_bar_pair_filter_score
   import lbps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [IDX_W-1:0]        req_first_index,
   input  logic [IDX_W-1:0]        req_second_index,
   input  logic [PIX_W-1:0]        req_a_center_x,
   input  logic [PIX_W-1:0]        req_a_center_y,
   input  logic [PIX_W-1:0]        req_a_width,
   input  logic [PIX_W-1:0]        req_a_height,
   input  logic signed [ANG_W-1:0] req_a_angle,
   input  logic [PIX_W-1:0]        req_b_center_x,
   input  logic [PIX_W-1:0]        req_b_center_y,
   input  logic [PIX_W-1:0]        req_b_width,
   input  logic [PIX_W-1:0]        req_b_height,
   input  logic signed [ANG_W-1:0] req_b_angle,
   output logic                    rsp_valid,
   output logic                    rsp_accepted,
   output logic [2:0]              rsp_reject_cause,
   output logic [CONF_W-1:0]       rsp_confidence,
   output logic [IDX_W-1:0]        rsp_left_index,
   output logic [IDX_W-1:0]        rsp_right_index,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int SIDE_W    = $bits(side_type);
   localparam int SIDE_N    = SQRT_W + RATIO_Q + 1 + SCORE_Q;
   localparam int SCORE_N   = 4 + SIDE_N - (SCORE_Q + 2);
   localparam int LATENCY   = 4 + SIDE_N + 3;

   cfg_type  cfg_ff;
   s1_type   s1_ff, s1_in;
   s2_type   s2_ff, s2_in;
   s3_type   s3_ff, s3_in;
   s4_type   s4_ff, s4_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_bar_aspect      <= RST_MIN_BAR_ASPECT;
         cfg_ff.max_bar_aspect      <= RST_MAX_BAR_ASPECT;
         cfg_ff.max_angle_diff      <= RST_MAX_ANGLE_DIFF;
         cfg_ff.max_size_mismatch   <= RST_MAX_SIZE_MISMATCH;
         cfg_ff.max_vertical_offset <= RST_MAX_VERTICAL_OFFSET;
         cfg_ff.min_spacing_ratio   <= RST_MIN_SPACING_RATIO;
         cfg_ff.max_spacing_ratio   <= RST_MAX_SPACING_RATIO;
         cfg_ff.ideal_spacing_ratio <= RST_IDEAL_SPACING_RATIO;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_BAR_ASPECT:      cfg_ff.min_bar_aspect      <= csr_data[9:0];
            CSR_MAX_BAR_ASPECT:      cfg_ff.max_bar_aspect      <= csr_data[9:0];
            CSR_MAX_ANGLE_DIFF:      cfg_ff.max_angle_diff      <= csr_data[14:0];
            CSR_MAX_SIZE_MISMATCH:   cfg_ff.max_size_mismatch   <= csr_data[8:0];
            CSR_MAX_VERTICAL_OFFSET: cfg_ff.max_vertical_offset <= csr_data[9:0];
            CSR_MIN_SPACING_RATIO:   cfg_ff.min_spacing_ratio   <= csr_data[9:0];
            CSR_MAX_SPACING_RATIO:   cfg_ff.max_spacing_ratio   <= csr_data[10:0];
            CSR_IDEAL_SPACING_RATIO: cfg_ff.ideal_spacing_ratio <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   function automatic logic aspect_bad(input logic [PIX_W-1:0] w,
                                       input logic [PIX_W-1:0] h,
                                       input cfg_type c);
      logic [25:0] ws;
      logic [25:0] up;
      logic [25:0] dn;
      ws = 26'({w, 8'h00});
      up = 26'(c.max_bar_aspect) * 26'(h);
      dn = 26'(c.min_bar_aspect) * 26'(h);
      return (w == '0) || (h == '0) || (ws > up) || (ws < dn);
   endfunction

   // Stage 1: fold the angle, take maxima, minima and differences
   logic signed [16:0] da;
   logic [16:0]        da_abs;
   logic [16:0]        ang_mod;
   logic [16:0]        ang_fold;

   always_comb begin
      da       = 17'(req_a_angle) - 17'(req_b_angle);
      da_abs   = da[16] ? 17'(-da) : 17'(da);
      ang_mod  = (da_abs >= HALF_TURN) ? da_abs - HALF_TURN : da_abs;
      ang_fold = (ang_mod > QUARTER_TURN) ? HALF_TURN - ang_mod : ang_mod;

      s1_in.valid = start & ~busy;
      s1_in.left  = (req_a_center_x < req_b_center_x) ? req_first_index : req_second_index;
      s1_in.right = (req_a_center_x < req_b_center_x) ? req_second_index : req_first_index;
      s1_in.ang   = ang_fold[14:0];
      s1_in.aw    = req_a_width;
      s1_in.ah    = req_a_height;
      s1_in.bw    = req_b_width;
      s1_in.bh    = req_b_height;
      s1_in.mh    = (req_a_height > req_b_height) ? req_a_height : req_b_height;
      s1_in.nh    = (req_a_height > req_b_height) ? req_b_height : req_a_height;
      s1_in.mw    = (req_a_width > req_b_width) ? req_a_width : req_b_width;
      s1_in.nw    = (req_a_width > req_b_width) ? req_b_width : req_a_width;
      s1_in.dh    = s1_in.mh - s1_in.nh;
      s1_in.dw    = s1_in.mw - s1_in.nw;
      s1_in.dx    = (req_a_center_x > req_b_center_x) ? req_a_center_x - req_b_center_x
                                                      : req_b_center_x - req_a_center_x;
      s1_in.dy    = (req_a_center_y > req_b_center_y) ? req_a_center_y - req_b_center_y
                                                      : req_b_center_y - req_a_center_y;
   end

   // Stage 2: threshold products and squares
   always_comb begin
      s2_in.valid      = s1_ff.valid;
      s2_in.left       = s1_ff.left;
      s2_in.right      = s1_ff.right;
      s2_in.aspect_bad = aspect_bad(s1_ff.aw, s1_ff.ah, cfg_ff) |
                         aspect_bad(s1_ff.bw, s1_ff.bh, cfg_ff);
      s2_in.angle_bad  = s1_ff.ang >= cfg_ff.max_angle_diff;
      s2_in.size_bad   = (25'({s1_ff.dh, 8'h00}) >
                          25'(cfg_ff.max_size_mismatch) * 25'(s1_ff.mh)) ||
                         (25'({s1_ff.dw, 8'h00}) >
                          25'(cfg_ff.max_size_mismatch) * 25'(s1_ff.mw));
      s2_in.vert_bad   = 26'({s1_ff.dy, 8'h00}) >
                         26'(cfg_ff.max_vertical_offset) * 26'(s1_ff.mh);
      s2_in.dx2        = 32'(s1_ff.dx) * 32'(s1_ff.dx);
      s2_in.dy2        = 32'(s1_ff.dy) * 32'(s1_ff.dy);
      s2_in.lo         = 26'(cfg_ff.min_spacing_ratio) * 26'(s1_ff.mh);
      s2_in.hi         = 27'(cfg_ff.max_spacing_ratio) * 27'(s1_ff.mh);
      s2_in.mh         = s1_ff.mh;
   end

   // Stage 3: squared distance and squared bounds
   always_comb begin
      s3_in.valid      = s2_ff.valid;
      s3_in.left       = s2_ff.left;
      s3_in.right      = s2_ff.right;
      s3_in.aspect_bad = s2_ff.aspect_bad;
      s3_in.angle_bad  = s2_ff.angle_bad;
      s3_in.size_bad   = s2_ff.size_bad;
      s3_in.vert_bad   = s2_ff.vert_bad;
      s3_in.d2         = 33'(s2_ff.dx2) + 33'(s2_ff.dy2);
      s3_in.lo2        = 52'(s2_ff.lo) * 52'(s2_ff.lo);
      s3_in.hi2        = 54'(s2_ff.hi) * 54'(s2_ff.hi);
      s3_in.mh         = s2_ff.mh;
   end

   // Stage 4: spacing test and first failing filter
   logic [SQRT_IN_W-1:0] lhs;
   logic                 spacing_bad;

   always_comb begin
      lhs         = {s3_ff.d2, 16'h0000};
      spacing_bad = (52'(lhs) < s3_ff.lo2) || (54'(lhs) > s3_ff.hi2);

      s4_in.valid = s3_ff.valid;
      s4_in.left  = s3_ff.left;
      s4_in.right = s3_ff.right;
      s4_in.mh    = s3_ff.mh;
      s4_in.lhs   = lhs;
      if (s3_ff.aspect_bad)      s4_in.cause = CAUSE_ASPECT;
      else if (s3_ff.angle_bad)  s4_in.cause = CAUSE_ANGLE;
      else if (s3_ff.size_bad)   s4_in.cause = CAUSE_SIZE;
      else if (s3_ff.vert_bad)   s4_in.cause = CAUSE_VERTICAL;
      else if (spacing_bad)      s4_in.cause = CAUSE_SPACING;
      else                       s4_in.cause = CAUSE_NONE;
   end

   // Advance the filter stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   // Size and angle scores, started from stage 1
   logic [SCORE_Q-1:0] sh;
   logic [SCORE_Q-1:0] sw;
   logic [SCORE_Q-1:0] sa;
   logic [15:0]        ang_den;

   assign ang_den = 16'(ANGLE_REF) + 16'(s1_ff.ang);

   lbps_div #(.NW(32), .DW(PIX_W), .QW(SCORE_Q)) u_div_h (
      .clock (clock),
      .num   ({s1_ff.nh, 16'h0000}),
      .den   (s1_ff.mh),
      .quo   (sh)
   );

   lbps_div #(.NW(32), .DW(PIX_W), .QW(SCORE_Q)) u_div_w (
      .clock (clock),
      .num   ({s1_ff.nw, 16'h0000}),
      .den   (s1_ff.mw),
      .quo   (sw)
   );

   lbps_div #(.NW(31), .DW(16), .QW(SCORE_Q)) u_div_ang (
      .clock (clock),
      .num   ({ANGLE_REF, 16'h0000}),
      .den   (ang_den),
      .quo   (sa)
   );

   // Combine width and height scores
   logic [33:0]        size_prod;
   logic [SCORE_Q-1:0] size_ff, size_in;
   logic [SCORE_Q-1:0] sa_ff;
   logic [SCORE_Q-1:0] size_d;
   logic [SCORE_Q-1:0] sa_d;

   assign size_prod = 34'(sh) * 34'(sw);
   assign size_in   = size_prod[32:16];

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      sa_ff   <= sa;
   end

   lbps_delay #(.W(2 * SCORE_Q), .N(SCORE_N)) u_dly_score (
      .clock (clock),
      .reset (reset),
      .din   ({size_ff, sa_ff}),
      .dout  ({size_d, sa_d})
   );

   // Centre distance, then spacing ratio over the taller height
   logic [SQRT_W-1:0]  dist8;
   logic [PIX_W-1:0]   mh_d;
   logic [RATIO_Q-1:0] r16;

   lbps_sqrt #(.VW(SQRT_IN_W)) u_sqrt (
      .clock (clock),
      .value (s4_ff.lhs),
      .root  (dist8)
   );

   lbps_delay #(.W(PIX_W), .N(SQRT_W)) u_dly_mh (
      .clock (clock),
      .reset (reset),
      .din   (s4_ff.mh),
      .dout  (mh_d)
   );

   lbps_div #(.NW(SQRT_W + 8), .DW(PIX_W), .QW(RATIO_Q)) u_div_ratio (
      .clock (clock),
      .num   ({dist8, 8'h00}),
      .den   (mh_d),
      .quo   (r16)
   );

   // Distance from the ideal ratio
   logic [RATIO_Q-1:0] ideal8;
   logic [RATIO_Q-1:0] rd;
   logic [19:0]        den_ff, den_in;
   logic [SCORE_Q-1:0] s_ratio;

   assign ideal8 = RATIO_Q'({cfg_ff.ideal_spacing_ratio, 8'h00});
   assign rd     = (r16 >= ideal8) ? r16 - ideal8 : ideal8 - r16;
   assign den_in = 20'h10000 + 20'(rd);

   always_ff @(posedge clock) begin
      den_ff <= den_in;
   end

   lbps_div #(.NW(33), .DW(20), .QW(SCORE_Q)) u_div_score (
      .clock (clock),
      .num   (33'h1_0000_0000),
      .den   (den_ff),
      .quo   (s_ratio)
   );

   // Carry cause and indices alongside the score path
   side_type side_d;
   logic [SIDE_W-1:0] side_vec;
   side_type side4;

   always_comb begin
      side4.valid = s4_ff.valid;
      side4.cause = s4_ff.cause;
      side4.left  = s4_ff.left;
      side4.right = s4_ff.right;
   end

   lbps_delay #(.W(SIDE_W), .N(SIDE_N)) u_dly_side (
      .clock (clock),
      .reset (reset),
      .din   (side4),
      .dout  (side_vec)
   );

   assign side_d = side_type'(side_vec);

   // Weighted sum, then divide by ten
   side_type    side1_ff, side2_ff;
   logic [19:0] sum1_ff, sum1_in;
   logic [19:0] sum2_ff;
   logic [37:0] prod_ff, prod_in;
   logic [16:0] q0;
   logic [20:0] ten_q;
   logic [16:0] quot;

   assign sum1_in = 20'(size_d) * 20'd3 + 20'(s_ratio) * 20'd4 + 20'(sa_d) * 20'd3 + 20'd5;
   assign prod_in = 38'(sum1_ff) * 38'(DIV10_MULT);
   assign q0      = prod_ff[DIV10_SHIFT +: 17];
   assign ten_q   = 21'(q0) * 21'd10;
   assign quot    = (ten_q > 21'(sum2_ff)) ? q0 - 17'd1 : q0;

   always_ff @(posedge clock) begin
      sum1_ff  <= sum1_in;
      sum2_ff  <= sum1_ff;
      prod_ff  <= prod_in;
      if (reset) begin
         side1_ff.valid <= 1'b0;
         side2_ff.valid <= 1'b0;
      end else begin
         side1_ff <= side_d;
         side2_ff <= side1_ff;
      end
   end

   // Drive the response for one cycle
   logic              rsp_valid_ff;
   logic              rsp_accepted_ff;
   logic [2:0]        rsp_cause_ff;
   logic [CONF_W-1:0] rsp_conf_ff;
   logic [IDX_W-1:0]  rsp_left_ff;
   logic [IDX_W-1:0]  rsp_right_ff;

   always_ff @(posedge clock) begin
      rsp_accepted_ff <= side2_ff.cause == CAUSE_NONE;
      rsp_cause_ff    <= side2_ff.cause;
      rsp_conf_ff     <= (side2_ff.cause == CAUSE_NONE) ? quot : '0;
      rsp_left_ff     <= side2_ff.left;
      rsp_right_ff    <= side2_ff.right;
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= side2_ff.valid;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_reject_cause = rsp_cause_ff;
   assign rsp_confidence   = rsp_conf_ff;
   assign rsp_left_index   = rsp_left_ff;
   assign rsp_right_index  = rsp_right_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("item taken but no response after the pipeline latency");

   a_accept_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_reject_cause == CAUSE_NONE)))
      else $error("accepted flag disagrees with reject cause");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (rsp_confidence == '0))
      else $error("rejected item carries a nonzero confidence");

   a_conf_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_confidence <= 17'h10000))
      else $error("confidence above one");
`endif

endmodule
